/* src/lxt_pkg.sv */
package lxt_pkg;

    // Result field widths are fixed by the interface.
    localparam int AMOUNT_W = 32;
    localparam int POS_W    = 16;

    // Result queue
    localparam int Q_DEPTH = 8;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    // Characters of the expression syntax
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic signed [1:0] DIR_BACK = -2'sd1;
    localparam logic signed [1:0] DIR_ABS  = 2'sd0;
    localparam logic signed [1:0] DIR_FWD  = 2'sd1;

    typedef enum logic [2:0] {
        KIND_LINE  = 3'd0,
        KIND_COL   = 3'd1,
        KIND_PCHAR = 3'd2,
        KIND_PEND  = 3'd3,
        KIND_OK    = 3'd4,
        KIND_ERR   = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic signed [1:0]    direction;
        logic [AMOUNT_W-1:0]  amount;
        logic [7:0]           pattern_char;
        logic [POS_W-1:0]     error_position;
        logic                 last;
    } res_t;

endpackage

/* src/location_expression_tokenizer.sv */
// Location expression tokenizer. Takes one byte of a zero-terminated location expression per
// transfer on the input channel and gives line/column tokens (direction plus a saturating decimal
// value), pattern characters, a pattern-end token, and end-ok at the zero or an error on the
// output channel. A byte is registered on acceptance and decoded in the following cycle; its
// results are written into the result queue, which drives the output. Input is taken at one
// byte per cycle while in_stall is low. Most bytes give zero or one result; a byte that ends a
// number can give two, and the output channel moves one result per cycle while out_stall is
// low, so a long run of such bytes is limited by the output side. An eight-entry result queue
// decouples the two sides: in_stall rises only when the queue cannot take the worst case of
// the byte in decode plus the byte being offered.
module location_expression_tokenizer
    import lxt_pkg::*;
#(
    parameter int VALUE_WIDTH  = 32,
    parameter int OFFSET_WIDTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          ch,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          kind,
    output logic signed [1:0]   direction,
    output logic [AMOUNT_W-1:0] amount,
    output logic [7:0]          pattern_char,
    output logic [POS_W-1:0]    error_position,
    output logic                last
);

    typedef enum logic [2:0] {
        MODE_START,
        MODE_NUM,
        MODE_PAT,
        MODE_ESC,
        MODE_DISCARD
    } mode_t;

    // Parser state carried from byte to byte
    typedef struct packed {
        mode_t                  mode;
        logic signed [1:0]      sign;
        logic [VALUE_WIDTH-1:0] acc;
        logic                   col;
        logic                   begun;
        logic                   any;
    } pst_t;

    localparam int AEXT = (VALUE_WIDTH > AMOUNT_W) ? VALUE_WIDTH : AMOUNT_W;
    localparam int OEXT = (OFFSET_WIDTH > POS_W) ? OFFSET_WIDTH : POS_W;
    // Worst case: two results from the byte in decode, two from the byte on offer
    localparam int ROOM_NEEDED = 2;

    localparam pst_t PST_RESET = '{
        mode:  MODE_START,
        sign:  DIR_ABS,
        acc:   '0,
        col:   1'b0,
        begun: 1'b0,
        any:   1'b0
    };

    function automatic logic [AMOUNT_W-1:0] sat_amount(input logic [VALUE_WIDTH-1:0] v);
        logic [AEXT-1:0] e;
        e = AEXT'(v);
        if (e > AEXT'({AMOUNT_W{1'b1}}))
            return '1;
        return e[AMOUNT_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic [OFFSET_WIDTH-1:0] v);
        logic [OEXT-1:0] e;
        e = OEXT'(v);
        if (e > OEXT'({POS_W{1'b1}}))
            return '1;
        return e[POS_W-1:0];
    endfunction

    function automatic res_t mk_res(input kind_t k, input logic signed [1:0] dir,
                                    input logic [AMOUNT_W-1:0] amt, input logic [7:0] pc,
                                    input logic [POS_W-1:0] pos);
        res_t r;
        r.kind           = k;
        r.direction      = dir;
        r.amount         = amt;
        r.pattern_char   = pc;
        r.error_position = pos;
        r.last           = 1'b0;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // First byte of a token
    function automatic void start_byte(input logic [7:0] c, input pst_t s,
                                       input logic [POS_W-1:0] pos,
                                       output pst_t ns, output logic has, output res_t r);
        logic [7:0] d;
        ns  = s;
        has = 1'b0;
        r   = '0;
        d   = c - CH_ZERO;
        if (c == CH_PLUS || c == CH_MINUS) begin
            ns.sign  = (c == CH_PLUS) ? DIR_FWD : DIR_BACK;
            ns.begun = 1'b1;
        end else if (c == CH_HASH) begin
            ns.col  = 1'b1;
            ns.acc  = '0;
            ns.mode = MODE_NUM;
        end else if (c == CH_QUOTE) begin
            ns.mode = MODE_PAT;
        end else if (is_digit(c)) begin
            ns.col  = 1'b0;
            ns.acc  = VALUE_WIDTH'(d[3:0]);
            ns.mode = MODE_NUM;
        end else if (c == CH_NUL) begin
            has = 1'b1;
            if (s.begun || !s.any)
                r = mk_res(KIND_ERR, DIR_ABS, '0, '0, pos);
            else
                r = mk_res(KIND_OK, DIR_ABS, '0, '0, '0);
        end else begin
            has     = 1'b1;
            r       = mk_res(KIND_ERR, DIR_ABS, '0, '0, pos);
            ns.mode = MODE_DISCARD;
        end
    endfunction

    // Input register
    logic [7:0] ch_reg;
    logic       vld_reg;

    pst_t                    st_reg, st_next;
    logic [OFFSET_WIDTH-1:0] off_reg, off_next;

    // Result queue
    res_t             q_reg [Q_DEPTH];
    logic [PTR_W-1:0] head_reg, tail_reg, head_next, tail_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    res_t             r0, r1;
    logic [1:0]       n_push;
    logic             pop;

    // Decode of the registered byte
    always_comb
    begin
        pst_t                   tmp;
        logic                   has;
        logic [VALUE_WIDTH+3:0] prod;
        logic [7:0]             d;
        logic [POS_W-1:0]       pos;

        st_next  = st_reg;
        off_next = off_reg;
        r0       = '0;
        r1       = '0;
        n_push   = 2'd0;
        tmp      = st_reg;
        has      = 1'b0;
        d        = ch_reg - CH_ZERO;
        pos      = sat_pos(off_reg);
        // acc * 10 + digit as two shifts and adds; high nibble set means overflow
        prod     = ({4'b0, st_reg.acc} << 3) + ({4'b0, st_reg.acc} << 1)
                   + (VALUE_WIDTH+4)'(d[3:0]);

        if (vld_reg) begin
            case (st_reg.mode)
                MODE_START:
                begin
                    start_byte(ch_reg, st_reg, pos, st_next, has, r0);
                    n_push = has ? 2'd1 : 2'd0;
                end
                MODE_NUM:
                begin
                    if (is_digit(ch_reg)) begin
                        if (prod[VALUE_WIDTH+3:VALUE_WIDTH] != 4'd0)
                            st_next.acc = '1;
                        else
                            st_next.acc = prod[VALUE_WIDTH-1:0];
                    end else begin
                        // token out, then the terminating byte starts the next token
                        r0 = mk_res(st_reg.col ? KIND_COL : KIND_LINE, st_reg.sign,
                                    sat_amount(st_reg.acc), '0, '0);
                        tmp       = st_reg;
                        tmp.any   = 1'b1;
                        tmp.mode  = MODE_START;
                        tmp.sign  = DIR_ABS;
                        tmp.begun = 1'b0;
                        tmp.acc   = '0;
                        tmp.col   = 1'b0;
                        start_byte(ch_reg, tmp, pos, st_next, has, r1);
                        n_push = has ? 2'd2 : 2'd1;
                    end
                end
                MODE_PAT:
                begin
                    if (ch_reg == CH_BSLASH) begin
                        st_next.mode = MODE_ESC;
                    end else if (ch_reg == CH_NUL) begin
                        r0     = mk_res(KIND_ERR, DIR_ABS, '0, '0, pos);
                        n_push = 2'd1;
                    end else if (ch_reg == CH_QUOTE) begin
                        r0            = mk_res(KIND_PEND, st_reg.sign, '0, '0, '0);
                        n_push        = 2'd1;
                        st_next.any   = 1'b1;
                        st_next.mode  = MODE_START;
                        st_next.sign  = DIR_ABS;
                        st_next.begun = 1'b0;
                    end else begin
                        r0     = mk_res(KIND_PCHAR, st_reg.sign, '0, ch_reg, '0);
                        n_push = 2'd1;
                    end
                end
                MODE_ESC:
                begin
                    n_push = 2'd1;
                    if (ch_reg == CH_NUL) begin
                        r0 = mk_res(KIND_ERR, DIR_ABS, '0, '0, pos);
                    end else begin
                        r0           = mk_res(KIND_PCHAR, st_reg.sign, '0, ch_reg, '0);
                        st_next.mode = MODE_PAT;
                    end
                end
                default:
                begin
                    // discarding through the next zero
                end
            endcase

            if (ch_reg == CH_NUL) begin
                st_next  = PST_RESET;
                off_next = '0;
            end else if (!(&off_reg)) begin
                off_next = off_reg + 1'b1;
            end

            if (n_push == 2'd1)
                r0.last = 1'b1;
            if (n_push == 2'd2)
                r1.last = 1'b1;
        end
    end

    // Queue bookkeeping
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign in_stall  = (cnt_reg + (vld_reg ? CNT_W'(ROOM_NEEDED) : '0))
                       > CNT_W'(Q_DEPTH - 2 * ROOM_NEEDED + ROOM_NEEDED);

    always_comb
    begin
        head_next = pop ? head_reg + 1'b1 : head_reg;
        tail_next = tail_reg + PTR_W'(n_push);
        cnt_next  = cnt_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg  <= 1'b0;
            st_reg   <= PST_RESET;
            off_reg  <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            vld_reg  <= in_valid && !in_stall;
            st_reg   <= st_next;
            off_reg  <= off_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Payload: no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            ch_reg <= ch;
        if (n_push != 2'd0)
            q_reg[tail_reg] <= r0;
        if (n_push == 2'd2)
            q_reg[tail_reg + 1'b1] <= r1;
    end

    assign kind           = q_reg[head_reg].kind;
    assign direction      = q_reg[head_reg].direction;
    assign amount         = q_reg[head_reg].amount;
    assign pattern_char   = q_reg[head_reg].pattern_char;
    assign error_position = q_reg[head_reg].error_position;
    assign last           = q_reg[head_reg].last;

endmodule

/* src/lxt_checker.sv */
module lxt_checker
    import lxt_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input logic [2:0]          kind,
    input logic signed [1:0]   direction,
    input logic [AMOUNT_W-1:0] amount,
    input logic [7:0]          pattern_char,
    input logic [POS_W-1:0]    error_position,
    input logic                last
);

    // Held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(amount)
            && $stable(last) && $stable(pattern_char) && $stable(error_position))
        else $error("result changed while stalled");

    // Only line and column tokens carry a value
    a_amount_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_LINE && kind != KIND_COL |-> amount == '0)
        else $error("amount on non-number result");

    // Error position only on errors
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_ERR |-> error_position == '0)
        else $error("error position on non-error result");

    // End-ok and error close their byte and carry no direction
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_OK || kind == KIND_ERR) |-> last && direction == DIR_ABS)
        else $error("bad end or error result");

endmodule

bind location_expression_tokenizer lxt_checker u_lxt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .direction      (direction),
    .amount         (amount),
    .pattern_char   (pattern_char),
    .error_position (error_position),
    .last           (last)
);
